// ----- src/lzss_pkg.sv -----
// shared types and constants for the lzss stream decompressor
// no dependencies; imported by every module of the block but lzss_ram

package lzss_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int RING_AW     = $clog2(WINDOW_SIZE);
    localparam int LEN_W       = 19;
    localparam int CNT_W       = 5;

    localparam logic [RING_AW-1:0] START_POSITION = RING_AW'(4078);
    localparam logic [LEN_W-1:0]   LEN_RESET      = LEN_W'(524280);
    localparam logic [3:0]         FLAGS_PER_BYTE = 4'd8;
    localparam logic [CNT_W-1:0]   MIN_LEN_M1     = CNT_W'(2);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       done_res;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_FLAG,
        KIND_LIT,
        KIND_REF1,
        KIND_REF2
    } t_kind;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_we;
        logic copy_en;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  first;
        logic  copy_last;
        logic  clr_last;
    } t_dp_sts;

endpackage

// ----- src/lzss_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/lzss_dp.sv -----
// datapath: parse state, history ring, copy pointers, length count, output register
// depends on lzss_pkg and lzss_ram

module lzss_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lzss_pkg::t_in_item  i_in_data,
    input  lzss_pkg::t_dp_cmd   i_cmd,
    output lzss_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lzss_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [lzss_pkg::LEN_W-1:0] i_cfg_data
);

    import lzss_pkg::*;

    logic [RING_AW-1:0] r_wp;
    logic [7:0]         r_flags;
    logic [3:0]         r_flags_left;
    logic               r_await;
    logic [7:0]         r_ref_low;
    logic [LEN_W-1:0]   r_count;
    logic [LEN_W-1:0]   r_out_len;
    logic [RING_AW-1:0] r_clr_cnt;
    logic [RING_AW-1:0] r_rd_addr;
    logic [CNT_W-1:0]   r_len_m1;
    logic [CNT_W-1:0]   r_k;
    logic               r_lit;
    logic [7:0]         r_lit_byte;
    logic               r_fwd;
    logic [7:0]         r_fwd_data;
    logic               r_out_valid;
    t_out_item          r_out;

    t_kind              kind;
    logic               eff_first;
    logic [RING_AW-1:0] n_rd_addr;
    logic [RING_AW-1:0] ref_pos;
    logic [7:0]         ram_rdata;
    logic [7:0]         src_byte;
    logic               out_free;
    logic               emit_ok;
    logic               advance;
    logic               done_now;
    logic [LEN_W-1:0]   count_inc;
    logic               ram_we;
    logic [RING_AW-1:0] ram_waddr;
    logic [7:0]         ram_wdata;

    assign eff_first = i_in_data.first;
    assign ref_pos   = {i_in_data.data_byte[7:4], r_ref_low};

    always_comb begin
        if (eff_first || r_flags_left == 4'd0) begin
            kind = KIND_FLAG;
        end else if (r_await) begin
            kind = KIND_REF2;
        end else if (r_flags[0]) begin
            kind = KIND_LIT;
        end else begin
            kind = KIND_REF1;
        end
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign emit_ok   = r_count < r_out_len;
    assign advance   = i_cmd.copy_en && (!emit_ok || out_free);
    assign count_inc = r_count + LEN_W'(1);
    assign done_now  = count_inc >= r_out_len;
    assign src_byte  = r_lit ? r_lit_byte : (r_fwd ? r_fwd_data : ram_rdata);

    always_comb begin
        if (i_cmd.accept && kind == KIND_REF2) begin
            n_rd_addr = ref_pos;
        end else if (advance) begin
            n_rd_addr = r_rd_addr + RING_AW'(1);
        end else begin
            n_rd_addr = r_rd_addr;
        end
    end

    assign ram_we    = i_cmd.clr_we || advance;
    assign ram_waddr = i_cmd.clr_we ? r_clr_cnt : r_wp;
    assign ram_wdata = i_cmd.clr_we ? 8'd0 : src_byte;

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_rd_addr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= START_POSITION;
            r_flags      <= 8'd0;
            r_flags_left <= 4'd0;
            r_await      <= 1'b0;
            r_count      <= '0;
            r_out_len    <= LEN_RESET;
            r_clr_cnt    <= '0;
            r_fwd        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_out_len <= i_cfg_data;
            end
            if (i_cmd.clr_we) begin
                r_clr_cnt <= r_clr_cnt + RING_AW'(1);
            end
            r_fwd <= advance && (r_wp == n_rd_addr);
            if (i_cmd.accept) begin
                if (eff_first) begin
                    r_wp    <= START_POSITION;
                    r_count <= '0;
                end
                case (kind)
                    KIND_FLAG: begin
                        r_flags      <= i_in_data.data_byte;
                        r_flags_left <= FLAGS_PER_BYTE;
                        r_await      <= 1'b0;
                    end
                    KIND_REF1: begin
                        r_await <= 1'b1;
                    end
                    KIND_REF2, KIND_LIT: begin
                        r_await      <= 1'b0;
                        r_flags      <= r_flags >> 1;
                        r_flags_left <= r_flags_left - 4'd1;
                    end
                    default: begin
                        r_await <= r_await;
                    end
                endcase
            end
            if (advance) begin
                r_wp <= r_wp + RING_AW'(1);
            end
            if (advance && emit_ok) begin
                r_out_valid <= 1'b1;
                r_count     <= count_inc;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_fwd_data <= src_byte;
        if (i_cmd.accept) begin
            case (kind)
                KIND_REF1: begin
                    r_ref_low <= i_in_data.data_byte;
                end
                KIND_REF2: begin
                    r_lit    <= 1'b0;
                    r_k      <= '0;
                    r_len_m1 <= CNT_W'(i_in_data.data_byte[3:0]) + MIN_LEN_M1;
                end
                KIND_LIT: begin
                    r_lit      <= 1'b1;
                    r_lit_byte <= i_in_data.data_byte;
                    r_k        <= '0;
                    r_len_m1   <= '0;
                end
                default: begin
                    r_lit <= r_lit;
                end
            endcase
        end
        if (advance) begin
            r_k <= r_k + CNT_W'(1);
        end
        if (advance && emit_ok) begin
            r_out.out_byte <= src_byte;
            r_out.last     <= (r_k == r_len_m1) || done_now;
            r_out.done_res <= done_now;
        end
    end

    assign o_sts.kind      = kind;
    assign o_sts.first     = eff_first;
    assign o_sts.copy_last = advance && (r_k == r_len_m1);
    assign o_sts.clr_last  = r_clr_cnt == '1;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_out))
        else $error("output register changed while stalled");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.copy_en |-> r_k <= r_len_m1)
        else $error("copy index past reference length");
    a_count_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !emit_ok && !i_cfg_valid |=> $stable(r_count))
        else $error("count moved after length reached");
    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> $past(advance))
        else $error("forward flag without a ring write");
`endif

endmodule

// ----- src/lzss_ctrl.sv -----
// controller: clear pass, item acceptance and copy sequencing
// depends on lzss_pkg

module lzss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lzss_pkg::t_dp_sts i_sts,
    output lzss_pkg::t_dp_cmd o_cmd
);

    import lzss_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.accept  = 1'b0;
        o_cmd.clr_we  = 1'b0;
        o_cmd.copy_en = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    if (i_sts.first) begin
                        n_state = ST_CLEAR;
                    end else if (i_sts.kind inside {KIND_LIT, KIND_REF2}) begin
                        n_state = ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                o_cmd.copy_en = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- src/lzss_stream_decompressor.sv -----
// lzss stream decompressor, 4096-byte history ring; top level
// depends on lzss_pkg, lzss_ctrl, lzss_dp (which holds lzss_ram)
// flag and first reference bytes are taken in the idle state; a literal then runs a copy of one byte
// a reference runs a copy of its length (3..18 bytes), one ring read and write per byte
// output register stalls on a full, untaken beat; config writes taken any cycle
// reset and any item with first set run a clear of all 4096 ring bytes, input not ready

module lzss_stream_decompressor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lzss_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lzss_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [lzss_pkg::LEN_W-1:0] i_cfg_data
);

    import lzss_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    lzss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lzss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ----- tb/lzss_stream_checker.sv -----
// checker for the lzss stream decompressor: watches the three channels,
// decodes accepted input beats into expected output beats and compares them
// depends on lzss_pkg

module lzss_stream_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  lzss_pkg::t_in_item          i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  lzss_pkg::t_out_item         i_out_data,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [lzss_pkg::LEN_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lzss_pkg::*;

    logic [7:0]         ring [WINDOW_SIZE];
    logic [RING_AW-1:0] wr_pos;
    logic [7:0]         flag_sr;
    logic [3:0]         flags_left;
    logic               want_second;
    logic [7:0]         ref_low;
    logic [19:0]        byte_count;
    logic [LEN_W-1:0]   len_limit;

    t_out_item          decoded_q [$];
    t_out_item          step_out [18];
    int                 step_n;
    int                 fails = 0;

    task automatic start_stream();
        for (int i = 0; i < WINDOW_SIZE; i++) ring[i] = 8'h00;
        wr_pos      = START_POSITION;
        flag_sr     = 8'h00;
        flags_left  = 4'd0;
        want_second = 1'b0;
        ref_low     = 8'h00;
        byte_count  = 20'd0;
    endtask

    task automatic put_byte(input logic [7:0] c);
        ring[wr_pos] = c;
        wr_pos = wr_pos + RING_AW'(1);
        if (byte_count < 20'(len_limit)) begin
            byte_count = byte_count + 20'd1;
            step_out[step_n].out_byte = c;
            step_out[step_n].last     = 1'b0;
            step_out[step_n].done_res = (byte_count >= 20'(len_limit));
            step_n++;
        end
    endtask

    task automatic decode_beat(input t_in_item it);
        logic [RING_AW-1:0] src;
        logic [RING_AW-1:0] rd;
        logic [4:0]         run;
        step_n = 0;
        if (it.first) start_stream();
        if (flags_left == 4'd0) begin
            flag_sr    = it.data_byte;
            flags_left = FLAGS_PER_BYTE;
        end else if (want_second) begin
            src = {it.data_byte[7:4], ref_low};
            run = {1'b0, it.data_byte[3:0]} + 5'd3;
            for (int k = 0; k < run; k++) begin
                rd = src + RING_AW'(k);
                put_byte(ring[rd]);
            end
            want_second = 1'b0;
            flag_sr     = flag_sr >> 1;
            flags_left  = flags_left - 4'd1;
        end else if (flag_sr[0]) begin
            put_byte(it.data_byte);
            flag_sr    = flag_sr >> 1;
            flags_left = flags_left - 4'd1;
        end else begin
            ref_low     = it.data_byte;
            want_second = 1'b1;
        end
        if (step_n > 0) step_out[step_n-1].last = 1'b1;
        for (int j = 0; j < step_n; j++) decoded_q.push_back(step_out[j]);
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            start_stream();
            len_limit = LEN_RESET;
            decoded_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) len_limit = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("output beat with nothing expected: out_byte %h",
                           i_out_data.out_byte);
                    fails++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte,
                               i_out_data.out_byte);
                        fails++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, i_out_data.last);
                        fails++;
                    end
                    if (i_out_data.done_res !== want.done_res) begin
                        $error("done_res: expected %b, got %b", want.done_res,
                               i_out_data.done_res);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) decode_beat(i_in_data);
        end
        o_pending    = decoded_q.size();
        o_fail_count = fails;
    end

endmodule

// ----- tb/tb_lzss_stream_decompressor.sv -----
// testbench top for the lzss stream decompressor: clock, reset, stimulus and verdict
// depends on lzss_pkg, lzss_stream_decompressor and lzss_stream_checker

module tb_lzss_stream_decompressor;
    timeunit 1ns;
    timeprecision 1ps;

    import lzss_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in_item         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data = '0;
    int               fail_count;
    int               pending;

    bit                 idle_on = 1'b1;
    bit                 long_hold_req = 1'b0;
    int                 items_sent = 0;
    logic [RING_AW-1:0] gen_pos = START_POSITION;

    lzss_stream_decompressor uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    lzss_stream_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("tb_lzss_stream_decompressor NOT OK");
        $finish;
    end

    // output side: random stall bursts plus one long hold-off that outlasts a ring clear
    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = 4600;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(input logic [7:0] b, input logic f);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, f};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic push_ref(input logic [RING_AW-1:0] pos, input logic [3:0] nib);
        push_item(pos[7:0], 1'b0);
        push_item({pos[11:8], nib}, 1'b0);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] v);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        // a reference past the length limit keeps the block busy with no beats out
        repeat (40) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_stream(input bit fresh);
        logic [7:0]         flags;
        logic [RING_AW-1:0] src;
        logic [3:0]         nib;
        int                 groups;
        groups = $urandom_range(1, 2);
        if (fresh) gen_pos = START_POSITION;
        for (int g = 0; g < groups; g++) begin
            flags = 8'($urandom_range(0, 255));
            push_item(flags, fresh && g == 0);
            for (int i = 0; i < 8; i++) begin
                if ($urandom_range(0, 39) == 0) begin
                    // broken stream: restart, sometimes between reference bytes
                    if (!flags[i]) push_item(8'($urandom), 1'b0);
                    push_item(8'($urandom), 1'b1);
                    gen_pos = START_POSITION;
                    return;
                end
                if (flags[i]) begin
                    push_item(8'($urandom), 1'b0);
                    gen_pos = gen_pos + RING_AW'(1);
                end else begin
                    nib = 4'($urandom);
                    case ($urandom_range(0, 5))
                        0: src = RING_AW'($urandom);
                        1: src = gen_pos;
                        default: src = gen_pos - RING_AW'($urandom_range(1, 40));
                    endcase
                    push_ref(src, nib);
                    gen_pos = gen_pos + RING_AW'(nib) + RING_AW'(3);
                end
            end
        end
    endtask

    initial begin : stim
        logic [LEN_W-1:0] len;
        int               phase;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // stream from the reset state, no start marker
        push_item(8'h63, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_ref(12'hFEF, 4'hF);
        push_ref(12'h002, 4'h0);
        push_ref(12'hFFF, 4'hF);
        push_item(8'h5A, 1'b0);
        push_item(8'hA5, 1'b0);
        push_ref(12'h000, 4'h0);

        // limit reached inside a reference, then fully suppressed reference
        write_len(19'd5);
        push_item(8'h01, 1'b1);
        push_item(8'h11, 1'b0);
        push_ref(12'hFEE, 4'hF);
        push_ref(12'hFEE, 4'h0);

        // limit lowered below the count
        write_len(19'd2);
        push_ref(12'hFEE, 4'h3);

        write_len(19'd0);
        push_item(8'hFF, 1'b1);
        push_item(8'h80, 1'b0);

        write_len('1);
        push_item(8'h01, 1'b0);

        phase = 0;
        while (items_sent < 190) begin
            case ($urandom_range(0, 4))
                0: len = 19'($urandom_range(0, 40));
                1: len = '1;
                2: len = LEN_RESET;
                default: len = 19'($urandom_range(41, 3000));
            endcase
            if (phase == 1) len = '1;
            write_len(len);
            if (phase == 1) long_hold_req = 1'b1;
            repeat ($urandom_range(1, 3)) send_stream($urandom_range(0, 5) != 0);
            if (items_sent > 160) idle_on = 1'b0;
            phase++;
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_lzss_stream_decompressor OK");
        end else begin
            $display("tb_lzss_stream_decompressor NOT OK");
        end
        $finish;
    end

endmodule
